### sv/vbl_pkg.sv
// ----------------------------------------------------------------------------
// vbl_pkg
// Shared types and constants for the value to bin range lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package vbl_pkg;

  localparam int TABLE_ROWS = 256;
  localparam int VALUE_BITS = 32;
  localparam int ROW_BITS   = 8;
  localparam int LIM_BITS   = 9;
  localparam int CFG_BITS   = 3;
  localparam int QUO_BITS   = 32;
  localparam int CNT_BITS   = 5;

  localparam logic [CFG_BITS-1:0] REG_BINNING_MODE    = 3'd0;
  localparam logic [CFG_BITS-1:0] REG_FIRST_BIN_START = 3'd1;
  localparam logic [CFG_BITS-1:0] REG_BIN_WIDTH       = 3'd2;
  localparam logic [CFG_BITS-1:0] REG_ROWS_IN_USE     = 3'd3;
  localparam logic [CFG_BITS-1:0] REG_USE_LOW_BOUND   = 3'd4;
  localparam logic [CFG_BITS-1:0] REG_USE_HIGH_BOUND  = 3'd5;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_WRITE  = 1'b1;

  localparam logic signed [VALUE_BITS-1:0] FIRST_BIN_RESET = -32'sd32768;
  localparam logic [30:0] BIN_WIDTH_RESET = 31'd65536;

  typedef struct packed {
    logic                          action;
    logic [ROW_BITS-1:0]           row_select;
    logic signed [VALUE_BITS-1:0]  row_low;
    logic signed [VALUE_BITS-1:0]  row_high;
    logic signed [VALUE_BITS-1:0]  query_value;
  } item_t;

  typedef struct packed {
    logic                found;
    logic [ROW_BITS-1:0] row_found;
  } result_t;

  typedef struct packed {
    logic                         valid;
    logic signed [VALUE_BITS-1:0] value;
    logic                         use_low;
    logic                         use_high;
    logic [LIM_BITS-1:0]          rows;
    logic                         hit;
    logic [ROW_BITS-1:0]          row;
  } token_t;

  typedef struct packed {
    logic                         en;
    logic [ROW_BITS-1:0]          row;
    logic signed [VALUE_BITS-1:0] low;
    logic signed [VALUE_BITS-1:0] high;
  } bound_wr_t;

endpackage

`default_nettype wire

### sv/vbl_cell.sv
// ----------------------------------------------------------------------------
// vbl_cell
// One table row: holds its bounds and tests the passing search token.
// ----------------------------------------------------------------------------
`default_nettype none

module vbl_cell import vbl_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [ROW_BITS-1:0] idx,
  input  wire bound_wr_t           wr,
  input  wire token_t              tok_in,
  output token_t                   tok_out
);

  logic signed [VALUE_BITS-1:0] low;
  logic signed [VALUE_BITS-1:0] high;
  logic match;

  always_comb begin
    match = tok_in.valid && !tok_in.hit && ({1'b0, idx} < tok_in.rows) &&
            (!tok_in.use_low || (low <= tok_in.value)) &&
            (!tok_in.use_high || (tok_in.value <= high));
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.row == idx) begin
      low  <= wr.low;
      high <= wr.high;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.value    <= tok_in.value;
    tok_out.use_low  <= tok_in.use_low;
    tok_out.use_high <= tok_in.use_high;
    tok_out.rows     <= tok_in.rows;
    tok_out.hit      <= tok_in.hit || match;
    tok_out.row      <= match ? idx : tok_in.row;
  end

endmodule

`default_nettype wire

### sv/value_to_bin_range_lookup.sv
// ----------------------------------------------------------------------------
// value_to_bin_range_lookup
// Maps a Q16.16 value to a table row by range search or regular binning.
// ----------------------------------------------------------------------------
// A write item, or a lookup that misses without work, gives its result in the cycle after acceptance.
// A table lookup walks a chain of 256 row cells to the result.
// A regular-binning lookup runs a radix-2 restoring divider to the result.
// One item is in work at a time; a new item can be accepted in the cycle its result is shown.
// Reset clears control state and loads register defaults; rows are undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module value_to_bin_range_lookup import vbl_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire item_t                 item,
  output logic                       done,
  output result_t                    result,
  input  wire logic                  wr_en,
  input  wire logic [CFG_BITS-1:0]   wr_index,
  input  wire logic [VALUE_BITS-1:0] wr_data
);

  typedef enum logic [1:0] {IDLE, DIV, SRCH} state_t;

  state_t state;
  logic binning_mode;
  logic signed [VALUE_BITS-1:0] first_bin_start;
  logic [30:0] bin_width;
  logic [LIM_BITS-1:0] rows_in_use;
  logic use_low_bound;
  logic use_high_bound;

  token_t tok [TABLE_ROWS+1];
  bound_wr_t wr;
  logic accept;
  logic [LIM_BITS-1:0] rows_lim;
  logic [VALUE_BITS:0] offset;
  logic [CNT_BITS-1:0] count;
  logic [QUO_BITS-1:0] rem;
  logic [QUO_BITS-1:0] dvd;
  logic [QUO_BITS-1:0] rem_sh;
  logic [QUO_BITS:0] trial;
  logic [QUO_BITS-1:0] quo_next;

  assign busy   = (state != IDLE);
  assign accept = start && !busy;
  assign rows_lim = (rows_in_use > LIM_BITS'(TABLE_ROWS)) ? LIM_BITS'(TABLE_ROWS) : rows_in_use;
  assign offset = {item.query_value[VALUE_BITS-1], item.query_value} -
                  {first_bin_start[VALUE_BITS-1], first_bin_start};
  assign rem_sh = {rem[QUO_BITS-2:0], dvd[QUO_BITS-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, bin_width};
  assign quo_next = {dvd[QUO_BITS-2:0], !trial[QUO_BITS]};

  always_comb begin
    wr.en   = accept && (item.action == ACT_WRITE);
    wr.row  = item.row_select;
    wr.low  = item.row_low;
    wr.high = item.row_high;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      binning_mode    <= 1'b0;
      first_bin_start <= FIRST_BIN_RESET;
      bin_width       <= BIN_WIDTH_RESET;
      rows_in_use     <= '0;
      use_low_bound   <= 1'b0;
      use_high_bound  <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_BINNING_MODE:    binning_mode    <= wr_data[0];
        REG_FIRST_BIN_START: first_bin_start <= wr_data;
        REG_BIN_WIDTH:       bin_width       <= wr_data[30:0];
        REG_ROWS_IN_USE:     rows_in_use     <= wr_data[LIM_BITS-1:0];
        REG_USE_LOW_BOUND:   use_low_bound   <= wr_data[0];
        REG_USE_HIGH_BOUND:  use_high_bound  <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      done         <= 1'b0;
      tok[0].valid <= 1'b0;
    end else begin
      done         <= 1'b0;
      tok[0].valid <= 1'b0;
      case (state)
        IDLE: begin
          if (accept) begin
            result <= '0;
            if (item.action == ACT_WRITE) begin
              done <= 1'b1;
            end else if (binning_mode) begin
              if (bin_width == '0 || offset[VALUE_BITS]) begin
                done <= 1'b1;
              end else begin
                rem   <= '0;
                dvd   <= offset[QUO_BITS-1:0];
                count <= '0;
                state <= DIV;
              end
            end else if (use_low_bound || use_high_bound) begin
              tok[0].valid <= 1'b1;
              state        <= SRCH;
            end else begin
              done <= 1'b1;
            end
          end
        end
        DIV: begin
          rem   <= trial[QUO_BITS] ? rem_sh : trial[QUO_BITS-1:0];
          dvd   <= quo_next;
          count <= count + 1'b1;
          if (count == '1) begin
            state <= IDLE;
            done  <= 1'b1;
            if (quo_next < {{(QUO_BITS-LIM_BITS){1'b0}}, rows_lim}) begin
              result.found     <= 1'b1;
              result.row_found <= quo_next[ROW_BITS-1:0];
            end
          end
        end
        SRCH: begin
          if (tok[TABLE_ROWS].valid) begin
            state            <= IDLE;
            done             <= 1'b1;
            result.found     <= tok[TABLE_ROWS].hit;
            result.row_found <= tok[TABLE_ROWS].hit ? tok[TABLE_ROWS].row : '0;
          end
        end
        default: state <= IDLE;
      endcase
    end
    tok[0].value    <= item.query_value;
    tok[0].use_low  <= use_low_bound;
    tok[0].use_high <= use_high_bound;
    tok[0].rows     <= rows_lim;
    tok[0].hit      <= 1'b0;
    tok[0].row      <= '0;
  end

  for (genvar i = 0; i < TABLE_ROWS; i++) begin : g_cell
    vbl_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (ROW_BITS'(i)),
      .wr      (wr),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  a_miss_row_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.row_found == '0)
    else $error("miss beat carries a nonzero row");

  a_token_in_search: assert property (@(posedge clk) disable iff (rst)
    tok[TABLE_ROWS].valid |-> state == SRCH)
    else $error("search token left the chain outside a search");

  a_div_width: assert property (@(posedge clk) disable iff (rst)
    state == DIV |-> bin_width != '0)
    else $error("divider running with zero bin width");

endmodule

`default_nettype wire
